>>> sv/highlight_recovery_exposure_macros.svh
// Assertion macros used by the highlight recovery and exposure top level.
// Each macro expects clk_i and rst_ni in the scope of the module that uses it.
`ifndef HIGHLIGHT_RECOVERY_EXPOSURE_MACROS_SVH
`define HIGHLIGHT_RECOVERY_EXPOSURE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define HRE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define HRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/hre_pkg.sv
// Package for the highlight recovery and exposure block: widths, payload
// structs, divider lane types and configuration register indexes. No dependencies.
`default_nettype none

package hre_pkg;

  // Channel word width and width of the recovered (capped) value
  localparam int unsigned ChanW   = 16;
  localparam int unsigned QuoW    = ChanW + 1;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ChanW-1:0] ClipReset = ChanW'(3891);
  localparam logic [ChanW-1:0] GainReset = ChanW'(6654);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLIP_LEVEL    = 2'd0,
    CFG_EXPOSURE_GAIN = 2'd1
  } hre_cfg_idx_e;

  typedef logic [ChanW-1:0] hre_chan_t;

  typedef struct packed {
    hre_chan_t red_in;
    hre_chan_t green_in;
    hre_chan_t blue_in;
  } hre_pix_in_t;

  typedef struct packed {
    hre_chan_t red_out;
    hre_chan_t green_out;
    hre_chan_t blue_out;
  } hre_pix_out_t;

  // One divider lane: partial remainder plus dividend/quotient shift register
  typedef struct packed {
    logic             ovf;
    logic [ChanW-1:0] rem;
    logic [QuoW-1:0]  qn;
  } hre_lane_t;

  typedef hre_lane_t [2:0] hre_lanes_t;

  // Per-pixel data carried alongside the divider (index 2 red, 1 green, 0 blue)
  typedef struct packed {
    hre_chan_t [2:0] ch;
    logic [2:0]      clipped;
    logic            rec_en;
    hre_chan_t       maxu;
  } hre_side_t;

endpackage

`default_nettype wire

>>> sv/hre_front.sv
// Front end: clip classification, dividend products and divider setup.
// Depends on hre_pkg.
`default_nettype none

module hre_front #(
  parameter int unsigned FracBits = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  hre_pkg::hre_pix_in_t data_i,
  input  hre_pkg::hre_chan_t  clip_i,
  output logic                valid_o,
  output hre_pkg::hre_side_t  side_o,
  output hre_pkg::hre_lanes_t lanes_o
);
  import hre_pkg::*;

  // maxu >= MinUnclip is the same as 100 * maxu >= 2^FracBits
  localparam int unsigned MinUnclip = ((32'd1 << FracBits) + 32'd99) / 32'd100;
  localparam int unsigned ProdW     = 2 * ChanW;

  hre_chan_t [2:0]         in_ch;
  logic [2:0]              in_clipped;
  hre_chan_t               in_maxu;
  hre_side_t               s1_side_d;
  logic [2:0][ProdW-1:0]   s2_prod_d;
  hre_lanes_t              s3_lanes_d;

  logic                    s1_valid_q, s2_valid_q, s3_valid_q;
  hre_side_t               s1_side_q, s2_side_q, s3_side_q;
  logic [2:0][ProdW-1:0]   s2_prod_q;
  hre_lanes_t              s3_lanes_q;

  // Classify channels, find largest unclipped channel
  always_comb begin
    in_ch   = {data_i.red_in, data_i.green_in, data_i.blue_in};
    in_maxu = '0;
    for (int i = 0; i < 3; i++) begin
      in_clipped[i] = in_ch[i] >= clip_i;
      if (!in_clipped[i] && (in_ch[i] > in_maxu)) begin
        in_maxu = in_ch[i];
      end
    end
    s1_side_d.ch      = in_ch;
    s1_side_d.clipped = in_clipped;
    s1_side_d.maxu    = in_maxu;
    s1_side_d.rec_en  = (in_clipped != 3'b000) && (in_clipped != 3'b111) &&
                        (32'(in_maxu) >= MinUnclip);
  end

  // Dividend c * clip for every channel
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_prod_d[i] = ProdW'(s1_side_q.ch[i]) * ProdW'(clip_i);
    end
  end

  // Upper dividend bits seed the remainder; a quotient that cannot fit
  // the recovered width is flagged and later replaced by the cap
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_lanes_d[i].ovf = {1'b0, s2_prod_q[i][ProdW-1:QuoW]} >= s2_side_q.maxu;
      s3_lanes_d[i].rem = ChanW'(s2_prod_q[i][ProdW-1:QuoW]);
      s3_lanes_d[i].qn  = s2_prod_q[i][QuoW-1:0];
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_side_q  <= s1_side_d;
      s2_side_q  <= s1_side_q;
      s2_prod_q  <= s2_prod_d;
      s3_side_q  <= s2_side_q;
      s3_lanes_q <= s3_lanes_d;
    end
  end

  assign valid_o = s3_valid_q;
  assign side_o  = s3_side_q;
  assign lanes_o = s3_lanes_q;

endmodule

`default_nettype wire

>>> sv/hre_div_cell.sv
// One cell of the restoring divider chain: one quotient bit for each of the
// three channel lanes per cycle while en_i is high. Depends on hre_pkg.
`default_nettype none

module hre_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  hre_pkg::hre_side_t  side_i,
  input  hre_pkg::hre_lanes_t lanes_i,
  output logic                valid_o,
  output hre_pkg::hre_side_t  side_o,
  output hre_pkg::hre_lanes_t lanes_o
);
  import hre_pkg::*;

  logic [2:0][ChanW:0] part;
  logic [2:0][ChanW:0] diff;
  logic [2:0]          ge;
  hre_lanes_t          lanes_d;

  logic                valid_q;
  hre_side_t           side_q;
  hre_lanes_t          lanes_q;

  // Shift next dividend bit into remainder, trial subtract the divisor
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      part[i]          = {lanes_i[i].rem, lanes_i[i].qn[QuoW-1]};
      ge[i]            = part[i] >= {1'b0, side_i.maxu};
      diff[i]          = part[i] - {1'b0, side_i.maxu};
      lanes_d[i].ovf   = lanes_i[i].ovf;
      lanes_d[i].rem   = ge[i] ? diff[i][ChanW-1:0] : part[i][ChanW-1:0];
      lanes_d[i].qn    = {lanes_i[i].qn[QuoW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q  <= side_i;
      lanes_q <= lanes_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign lanes_o = lanes_q;

endmodule

`default_nettype wire

>>> sv/hre_back.sv
// Back end: cap and select the recovered channels, apply exposure gain,
// truncate and saturate. Depends on hre_pkg.
`default_nettype none

module hre_back #(
  parameter int unsigned FracBits = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  hre_pkg::hre_side_t   side_i,
  input  hre_pkg::hre_lanes_t  lanes_i,
  input  hre_pkg::hre_chan_t   clip_i,
  input  hre_pkg::hre_chan_t   gain_i,
  output logic                 valid_o,
  output hre_pkg::hre_pix_out_t data_o
);
  import hre_pkg::*;

  localparam int unsigned ProdW = QuoW + ChanW;

  logic [ChanW+1:0]        sum3;
  logic [QuoW-1:0]         cap;
  logic [2:0][QuoW-1:0]    rcv;
  logic [2:0][QuoW-1:0]    vsel;
  logic [2:0][ProdW-1:0]   prod_d;
  logic [2:0][ProdW-1:0]   shifted;
  hre_chan_t [2:0]         chan;

  logic                    valid_q;
  logic [2:0][ProdW-1:0]   prod_q;

  // Cap is 1.5 * clip, truncated
  assign sum3 = {1'b0, clip_i, 1'b0} + {2'b00, clip_i};
  assign cap  = sum3[ChanW+1:1];

  // Recovered value limited to the cap, then the exposure product
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rcv[i]    = (lanes_i[i].ovf || (lanes_i[i].qn > cap)) ? cap : lanes_i[i].qn;
      vsel[i]   = (side_i.rec_en && side_i.clipped[i]) ? rcv[i] : {1'b0, side_i.ch[i]};
      prod_d[i] = ProdW'(vsel[i]) * ProdW'(gain_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // Drop fraction bits, saturate to the channel width
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shifted[i] = prod_q[i] >> FracBits;
      chan[i]    = (|shifted[i][ProdW-1:ChanW]) ? {ChanW{1'b1}} : shifted[i][ChanW-1:0];
    end
  end

  assign valid_o          = valid_q;
  assign data_o.red_out   = chan[2];
  assign data_o.green_out = chan[1];
  assign data_o.blue_out  = chan[0];

endmodule

`default_nettype wire

>>> sv/hre_skid.sv
// Output register with a skid stage; its registered full flag freezes the
// pipeline. Depends on hre_pkg.
`default_nettype none

module hre_skid (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  hre_pkg::hre_pix_out_t data_i,
  output logic                  adv_o,
  output logic                  out_valid_o,
  output hre_pkg::hre_pix_out_t out_data_o,
  input  logic                  out_stall_i
);
  import hre_pkg::*;

  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  hre_pix_out_t out_data_q, skid_data_q;
  logic         take, load_out, load_skid, out_from_skid;

  assign take  = out_valid_q && !out_stall_i;
  assign adv_o = !skid_valid_q;

  // Route incoming pixel to the output register or the skid register
  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    priority if (skid_valid_q) begin
      if (take) begin
        out_from_skid = 1'b1;
        skid_valid_d  = 1'b0;
      end
    end else if (valid_i) begin
      if (!out_valid_q || take) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else begin
      // Nothing new: the output empties once taken
      out_valid_d = out_valid_q && !take;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= data_i;
    end else if (out_from_skid) begin
      out_data_q <= skid_data_q;
    end
    if (load_skid) begin
      skid_data_q <= data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> sv/highlight_recovery_exposure.sv
// Highlight recovery and exposure top level; uses hre_pkg and all hre_* modules.
// Pipeline: 3 front stages, one divider cell per quotient bit (17 cells), the
// product register and the output register.
// Throughput: one pixel per cycle; the input stalls only while the skid stage holds.
// Reset: pipeline and output emptied, clip_level 3891, exposure_gain 6654.
`default_nettype none
`include "highlight_recovery_exposure_macros.svh"

module highlight_recovery_exposure #(
  parameter int unsigned FracBits = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  hre_pkg::hre_pix_in_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output hre_pkg::hre_pix_out_t  out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [hre_pkg::CfgIdxW-1:0] cfg_index_i,
  input  hre_pkg::hre_chan_t     cfg_data_i
);
  import hre_pkg::*;

  hre_chan_t    clip_q, gain_q;
  logic         adv;
  logic         back_valid;
  hre_pix_out_t back_data;

  logic [QuoW:0] chain_valid;
  hre_side_t     chain_side  [QuoW+1];
  hre_lanes_t    chain_lanes [QuoW+1];

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= ClipReset;
      gain_q <= GainReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (hre_cfg_idx_e'(cfg_index_i))
        CFG_CLIP_LEVEL:    clip_q <= cfg_data_i;
        CFG_EXPOSURE_GAIN: gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = !adv;

  hre_front #(
    .FracBits(FracBits)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(in_valid_i),
    .data_i (in_data_i),
    .clip_i (clip_q),
    .valid_o(chain_valid[0]),
    .side_o (chain_side[0]),
    .lanes_o(chain_lanes[0])
  );

  // Divider chain, one quotient bit per cell
  for (genvar k = 0; k < QuoW; k++) begin : g_cell
    hre_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(chain_valid[k]),
      .side_i (chain_side[k]),
      .lanes_i(chain_lanes[k]),
      .valid_o(chain_valid[k+1]),
      .side_o (chain_side[k+1]),
      .lanes_o(chain_lanes[k+1])
    );
  end

  hre_back #(
    .FracBits(FracBits)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(chain_valid[QuoW]),
    .side_i (chain_side[QuoW]),
    .lanes_i(chain_lanes[QuoW]),
    .clip_i (clip_q),
    .gain_i (gain_q),
    .valid_o(back_valid),
    .data_o (back_data)
  );

  hre_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (back_valid),
    .data_i     (back_data),
    .adv_o      (adv),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

  // A pixel arriving at a held output parks in the skid stage and stalls input
  `HRE_ASSERT_NEXT(a_skid_fill, back_valid && adv && out_valid_o && out_stall_i, in_stall_o, "pixel at held output did not stall input")
  // The skid stage is only ever full behind a full output register
  `HRE_ASSERT_IMPL(a_stall_has_out, in_stall_o, out_valid_o, "input stalled with empty output")
  // A new result only appears when the pipeline delivered one
  `HRE_ASSERT_IMPL(a_out_source, $rose(out_valid_o), $past(back_valid && adv), "output valid without a delivered pixel")

endmodule

`default_nettype wire

>>> verif/highlight_recovery_exposure_tb.sv
// Testbench for highlight_recovery_exposure: random and directed RGB pixels against
// a built-in recovery/exposure predictor. Depends on hre_pkg and the block's RTL only.
`timescale 1ns / 100ps

module highlight_recovery_exposure_tb;
  import hre_pkg::*;

  localparam int unsigned FracBits = 12;
  localparam time         ClkHalf  = 5ns;
  localparam int          DrainGap = 30;  // settle margin after the last expected pixel
  localparam logic [CfgIdxW-1:0] UnmappedIdx = 2'd3;
  localparam logic [63:0] ChanMax = (64'd1 << ChanW) - 1;

  // Predicts each pixel at acceptance and holds the expected pixels in order
  class pixel_scoreboard;
    hre_chan_t    clip_level;
    hre_chan_t    exposure_gain;
    hre_pix_out_t expected_pixels[$];
    int           mismatches;

    function new();
      clip_level    = ClipReset;
      exposure_gain = GainReset;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, hre_chan_t value);
      case (idx)
        CFG_CLIP_LEVEL:    clip_level = value;
        CFG_EXPOSURE_GAIN: exposure_gain = value;
        default: ;  // unmapped index, write dropped
      endcase
    endfunction

    // Scale by the exposure gain, truncate and saturate one channel
    function hre_chan_t expose(logic [63:0] v);
      logic [63:0] p;
      p = (v * exposure_gain) >> FracBits;
      return (p > ChanMax) ? ChanMax[ChanW-1:0] : p[ChanW-1:0];
    endfunction

    function hre_pix_out_t recover_expose(hre_pix_in_t px);
      logic [63:0]  ch[3];
      bit           clipped[3];
      int           nclip;
      logic [63:0]  maxu;
      logic [63:0]  cap;
      logic [63:0]  v;
      hre_pix_out_t res;
      ch[0] = 64'(px.red_in);
      ch[1] = 64'(px.green_in);
      ch[2] = 64'(px.blue_in);
      nclip = 0;
      maxu  = '0;
      for (int i = 0; i < 3; i++) begin
        clipped[i] = ch[i] >= clip_level;
        if (clipped[i]) nclip++;
        else if (ch[i] > maxu) maxu = ch[i];
      end
      // Recover only with one or two clipped and a usable unclipped channel (>= 0.01)
      if (nclip >= 1 && nclip <= 2 && 100 * maxu >= (64'd1 << FracBits)) begin
        cap = (3 * 64'(clip_level)) >> 1;
        for (int i = 0; i < 3; i++) begin
          if (clipped[i]) begin
            v     = (ch[i] * clip_level) / maxu;
            ch[i] = (v < cap) ? v : cap;
          end
        end
      end
      res.red_out   = expose(ch[0]);
      res.green_out = expose(ch[1]);
      res.blue_out  = expose(ch[2]);
      return res;
    endfunction

    function void note_pixel(hre_pix_in_t px);
      expected_pixels.push_back(recover_expose(px));
    endfunction

    function void check_pixel(hre_pix_out_t got);
      hre_pix_out_t exp_px;
      if (expected_pixels.size() == 0) begin
        $error("unexpected output pixel %h", got);
        mismatches++;
        return;
      end
      exp_px = expected_pixels.pop_front();
      if (got.red_out !== exp_px.red_out) begin
        $error("red_out: expected %0d, actual %0d", exp_px.red_out, got.red_out);
        mismatches++;
      end
      if (got.green_out !== exp_px.green_out) begin
        $error("green_out: expected %0d, actual %0d", exp_px.green_out, got.green_out);
        mismatches++;
      end
      if (got.blue_out !== exp_px.blue_out) begin
        $error("blue_out: expected %0d, actual %0d", exp_px.blue_out, got.blue_out);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  hre_pix_in_t         in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  hre_pix_out_t        out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_CLIP_LEVEL;
  hre_chan_t           cfg_data_i  = '0;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_cycles = 0;

  pixel_scoreboard sb = new();

  highlight_recovery_exposure #(
    .FracBits(FracBits)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #ClkHalf clk_i = ~clk_i;

  // Receiver: random stall, or a counted hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitors: requests, results and register writes, sampled at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.note_pixel(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_pixel(out_data_o);
    end
  end

  function automatic hre_pix_in_t make_pixel(int r, int g, int b);
    hre_pix_in_t px;
    px.red_in   = r[ChanW-1:0];
    px.green_in = g[ChanW-1:0];
    px.blue_in  = b[ChanW-1:0];
    return px;
  endfunction

  function automatic hre_chan_t chan_below(hre_chan_t clip);
    if (clip == 0) return '0;
    if ($urandom_range(3) == 0) return hre_chan_t'($urandom_range(clip - 1, 0) % 200);
    return hre_chan_t'($urandom_range(clip - 1, 0));
  endfunction

  function automatic hre_chan_t chan_clipped(hre_chan_t clip);
    return hre_chan_t'($urandom_range(32'(ChanMax), clip));
  endfunction

  // Mostly one or two clipped channels with random content; some noise
  function automatic hre_pix_in_t random_pixel(hre_chan_t clip);
    hre_chan_t c[3];
    int        mode;
    int        pos;
    mode = $urandom_range(9);
    pos  = $urandom_range(2);
    for (int i = 0; i < 3; i++) c[i] = chan_below(clip);
    case (mode)
      0: for (int i = 0; i < 3; i++) c[i] = hre_chan_t'($urandom);
      1, 2, 3, 4: c[pos] = chan_clipped(clip);
      5, 6, 7: begin
        for (int i = 0; i < 3; i++) c[i] = chan_clipped(clip);
        c[pos] = chan_below(clip);
      end
      8: begin
        // unclipped channels around the 0.01 threshold
        for (int i = 0; i < 3; i++) begin
          c[i] = hre_chan_t'($urandom_range(46, 36));
          if (c[i] >= clip) c[i] = chan_below(clip);
        end
        c[pos] = chan_clipped(clip);
      end
      default: for (int i = 0; i < 3; i++) c[i] = chan_clipped(clip);
    endcase
    return make_pixel(c[0], c[1], c[2]);
  endfunction

  task automatic send_pixel(hre_pix_in_t px);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop offering, let every expected pixel arrive, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    // let the monitor note the last accepted request first
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainGap) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, hre_chan_t value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(hre_chan_t clip, hre_chan_t gain);
    drain();
    write_reg(CFG_CLIP_LEVEL, clip);
    write_reg(CFG_EXPOSURE_GAIN, gain);
  endtask

  task automatic random_phase(hre_chan_t clip, hre_chan_t gain, int idle, int stall, int n);
    set_regs(clip, gain);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) send_pixel(random_pixel(sb.clip_level));
  endtask

  // Stimulus
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels at the reset settings (clip 3891)
    send_pixel(make_pixel(0, 0, 0));
    send_pixel(make_pixel(65535, 65535, 65535));
    send_pixel(make_pixel(3890, 3890, 3890));
    send_pixel(make_pixel(3891, 0, 0));
    send_pixel(make_pixel(3891, 41, 0));
    send_pixel(make_pixel(3891, 40, 40));
    send_pixel(make_pixel(65535, 2000, 100));
    send_pixel(make_pixel(4000, 4000, 3000));
    send_pixel(make_pixel(65535, 65535, 41));
    send_pixel(make_pixel(3000, 65535, 1000));
    send_pixel(make_pixel(1000, 2000, 65535));
    send_pixel(make_pixel(5000, 3890, 3890));
    send_pixel(make_pixel('hAAAA, 'h5555, 'h1234));
    send_pixel(make_pixel('h5555, 'hAAAA, 'hFFFF));
    // Clip level zero: everything clipped, no recovery
    set_regs('0, 16'd4096);
    send_pixel(make_pixel(65535, 100, 0));
    send_pixel(make_pixel(3891, 41, 2000));
    // Gain zero: all outputs zero
    set_regs(16'd3891, '0);
    send_pixel(make_pixel(65535, 65535, 65535));
    send_pixel(make_pixel(65535, 2000, 100));
    // Unmapped index must leave both registers alone
    drain();
    write_reg(UnmappedIdx, 16'hFFFF);
    send_pixel(make_pixel(3891, 1000, 500));

    // Random phases across settings and idling modes
    random_phase(16'd3891, 16'd6654, 0, 0, 250);
    random_phase(16'd65535, 16'd65535, 68, 0, 200);
    random_phase(16'd1, 16'd0, 0, 68, 100);
    random_phase(16'd2048, 16'd4096, 0, 68, 250);
    random_phase(hre_chan_t'($urandom_range(65535, 1)), hre_chan_t'($urandom), 17, 17, 250);

    // Long receiver hold-off while the sender keeps offering
    set_regs(16'd8000, 16'd3000);
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles <= 300;
    repeat (200) send_pixel(random_pixel(sb.clip_level));

    random_phase(16'd41, 16'd65535, 17, 17, 150);
    random_phase(hre_chan_t'($urandom_range(65535, 1)), hre_chan_t'($urandom_range(8192, 1)),
                 0, 0, 150);

    drain();
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Limit on the whole run
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
